>>> src/tlvrx_pkg.sv
// shared types, protocol codes and the crc-32 byte step for the tlv receiver
package tlvrx_pkg;

	localparam int unsigned CFG_W = 24;

	localparam logic [3:0]  HDR_BYTES    = 4'd8;
	localparam logic [31:0] FIRST_BYTES  = 32'd4;
	localparam logic [31:0] SMALL_MIN    = 32'd4;
	localparam logic [31:0] SMALL_MAX    = 32'd256;
	localparam logic [CFG_W-1:0] MAX_BLOCK_RST = 24'd32768;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// message type codes
	localparam logic [31:0] MSG_CAPS  = 32'h01;
	localparam logic [31:0] MSG_START = 32'h03;
	localparam logic [31:0] MSG_CSUM  = 32'h05;
	localparam logic [31:0] MSG_DATA  = 32'h06;
	localparam logic [31:0] MSG_STOP  = 32'h08;

	typedef enum logic [2:0] {
		KIND_CAPS      = 3'd0,
		KIND_START_ACK = 3'd1,
		KIND_SIZE_ERR  = 3'd2,
		KIND_CRC_BAD   = 3'd3,
		KIND_BLOCK_OK  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [31:0]       requested_size;
		logic [CFG_W-1:0]  size_limit;
		logic [31:0]       computed_crc;
		logic [31:0]       bytes_received;
		logic [31:0]       blocks_received;
		logic [31:0]       crc_errors;
		logic              test_running;
	} resp_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
			input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

>>> src/tlvrx_engine.sv
// deframing state, crc accumulation and message completion decode
module tlvrx_engine import tlvrx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	input  logic [CFG_W-1:0] max_block,
	output logic             emit,
	output resp_t            resp
);

	logic [3:0]  hc_q, hc_d;
	logic [63:0] hw_q, hw_d, hw_shift;
	logic [31:0] pc_q, pc_d;
	logic [31:0] fw_q, fw_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] exp_q, exp_d;
	logic        flag_q, flag_d;
	logic [31:0] bytes_q, bytes_d;
	logic [31:0] blocks_q, blocks_d;
	logic [31:0] errs_q, errs_d;
	logic [31:0] frame_type, msg_len, calc_crc, max_ext;
	logic        done, small_ok, blk_ok;

	always_comb begin
		hc_d     = hc_q;
		hw_d     = hw_q;
		pc_d     = pc_q;
		fw_d     = fw_q;
		crc_d    = crc_q;
		exp_d    = exp_q;
		flag_d   = flag_q;
		bytes_d  = bytes_q;
		blocks_d = blocks_q;
		errs_d   = errs_q;
		done     = 1'b0;
		emit     = 1'b0;
		hw_shift = {hw_q[55:0], byte_in};
		max_ext  = {{(32-CFG_W){1'b0}}, max_block};
		resp     = '0;

		if (hc_q != HDR_BYTES) begin
			hw_d       = hw_shift;
			hc_d       = hc_q + 4'd1;
			frame_type = hw_shift[63:32];
			msg_len    = hw_shift[31:0];
			if (hc_q == HDR_BYTES - 4'd1) begin
				pc_d  = '0;
				fw_d  = '0;
				crc_d = CRC_INIT;
				done  = (msg_len == 32'd0);
			end
		end else begin
			frame_type = hw_q[63:32];
			msg_len    = hw_q[31:0];
			if (pc_q < FIRST_BYTES) begin
				fw_d = {fw_q[23:0], byte_in};
			end
			crc_d = crc_byte(crc_q, byte_in);
			pc_d  = pc_q + 32'd1;
			if (pc_d == msg_len) begin
				done = 1'b1;
				pc_d = '0;
			end
		end

		calc_crc = ~crc_d;
		small_ok = (msg_len >= SMALL_MIN) && (msg_len <= SMALL_MAX);
		blk_ok   = (msg_len != 32'd0) && (msg_len <= max_ext);

		if (done) begin
			hc_d = '0;
			hw_d = '0;
			unique case (frame_type)
				MSG_CAPS: begin
					emit      = 1'b1;
					resp.kind = KIND_CAPS;
				end
				MSG_START: begin
					if (small_ok) begin
						emit                = 1'b1;
						resp.requested_size = fw_d;
						if (fw_d > max_ext) begin
							resp.kind = KIND_SIZE_ERR;
						end else begin
							resp.kind = KIND_START_ACK;
							flag_d    = 1'b1;
							bytes_d   = '0;
							blocks_d  = '0;
							errs_d    = '0;
						end
					end
				end
				MSG_CSUM: begin
					if (small_ok) begin
						exp_d = fw_d;
					end
				end
				MSG_DATA: begin
					if (blk_ok) begin
						emit              = 1'b1;
						bytes_d           = bytes_q + msg_len;
						blocks_d          = blocks_q + 32'd1;
						resp.computed_crc = calc_crc;
						if (calc_crc != exp_q) begin
							errs_d    = errs_q + 32'd1;
							resp.kind = KIND_CRC_BAD;
						end else begin
							resp.kind = KIND_BLOCK_OK;
						end
					end
				end
				MSG_STOP: begin
					flag_d = 1'b0;
				end
				default: begin
				end
			endcase
		end

		resp.size_limit      = max_block;
		resp.bytes_received  = bytes_d;
		resp.blocks_received = blocks_d;
		resp.crc_errors      = errs_d;
		resp.test_running    = flag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q     <= '0;
			hw_q     <= '0;
			pc_q     <= '0;
			fw_q     <= '0;
			crc_q    <= CRC_INIT;
			exp_q    <= '0;
			flag_q   <= 1'b0;
			bytes_q  <= '0;
			blocks_q <= '0;
			errs_q   <= '0;
		end else if (step) begin
			hc_q     <= hc_d;
			hw_q     <= hw_d;
			pc_q     <= pc_d;
			fw_q     <= fw_d;
			crc_q    <= crc_d;
			exp_q    <= exp_d;
			flag_q   <= flag_d;
			bytes_q  <= bytes_d;
			blocks_q <= blocks_d;
			errs_q   <= errs_d;
		end
	end

endmodule

>>> src/tlv_message_receiver_crc32_core.sv
// top level of the tlv message receiver with crc-32 block check
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   data_byte
// out       output     out_valid / out_ready response_kind .. test_running
// cfg       input      cfg_valid / cfg_ready cfg_data (max block size)
//
// one stream byte per cycle sustained while results are read; a result is registered
// from the byte that completes its message (input register, then result register)
// the throughput is set by the combinational crc byte step and state update
// arst_n clears the control and engine state; max block size resets to 32768
// an unread result holds the byte in the input register, and with it the input
module tlv_message_receiver_crc32_core import tlvrx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       response_kind,
	output logic [31:0]      requested_size,
	output logic [CFG_W-1:0] size_limit,
	output logic [31:0]      computed_crc,
	output logic [31:0]      bytes_received,
	output logic [31:0]      blocks_received,
	output logic [31:0]      crc_errors,
	output logic             test_running,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             emit;
	resp_t            resp;
	resp_t            resp_q;
	logic             out_valid_q;
	logic [CFG_W-1:0] max_block_q;

	// the byte in stage 1 moves on unless an unread result blocks the slot
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_block_q <= MAX_BLOCK_RST;
		end else if (cfg_valid) begin
			max_block_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	tlvrx_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.max_block (max_block_q),
		.emit      (emit),
		.resp      (resp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			resp_q <= resp;
		end
	end

	assign out_valid       = out_valid_q;
	assign response_kind   = resp_q.kind;
	assign requested_size  = resp_q.requested_size;
	assign size_limit      = resp_q.size_limit;
	assign computed_crc    = resp_q.computed_crc;
	assign bytes_received  = resp_q.bytes_received;
	assign blocks_received = resp_q.blocks_received;
	assign crc_errors      = resp_q.crc_errors;
	assign test_running    = resp_q.test_running;

endmodule

>>> sim/tb_tlv_message_receiver_crc32_core.sv
// self-checking testbench for the tlv message receiver with crc-32 block check
module tb_tlv_message_receiver_crc32_core;
	import tlvrx_pkg::*;

	// run limits
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 6;      // two-stage result path plus margin
	localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
	localparam int HOLD_AFTER   = 40;     // bytes accepted before the hold-off starts
	localparam int PHASE_BYTES  = 30;     // stream bytes per random phase

	// dut ports; the inputs driven here are known from time zero
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       data_byte = 8'd0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       response_kind;
	logic [31:0]      requested_size;
	logic [CFG_W-1:0] size_limit;
	logic [31:0]      computed_crc;
	logic [31:0]      bytes_received;
	logic [31:0]      blocks_received;
	logic [31:0]      crc_errors;
	logic             test_running;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	tlv_message_receiver_crc32_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.response_kind   (response_kind),
		.requested_size  (requested_size),
		.size_limit      (size_limit),
		.computed_crc    (computed_crc),
		.bytes_received  (bytes_received),
		.blocks_received (blocks_received),
		.crc_errors      (crc_errors),
		.test_running    (test_running),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	// 20 time unit clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// stream bytes waiting to be sent and the responses they should produce
	logic [7:0] tx_bytes[$];
	resp_t      resp_expect[$];
	logic [7:0] body[$];          // payload of the message being built

	int  queued_cnt   = 0;
	int  accepted_cnt = 0;
	int  results_seen = 0;
	int  fails        = 0;
	int  cycle_cnt    = 0;
	int  send_gap     = 0;
	int  recv_wait    = 0;
	bit  steady       = 1'b0;     // no idling on either side while set
	logic hold_off    = 1'b0;

	// ------------------------------------------------------------------
	// receiver shadow: same framing, crc and counters as the block
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] limit_cfg   = MAX_BLOCK_RST;
	logic [3:0]       hdr_cnt     = '0;
	logic [63:0]      hdr         = '0;   // type in the upper word, length in the lower
	logic [31:0]      pay_cnt     = '0;
	logic [31:0]      lead_word   = '0;   // first four payload bytes, big-endian
	logic [31:0]      crc_run     = CRC_INIT;
	logic [31:0]      crc_expect  = '0;
	logic             running     = 1'b0;
	logic [31:0]      rx_bytes    = '0;
	logic [31:0]      rx_blocks   = '0;
	logic [31:0]      rx_crc_errs = '0;

	// reflected crc-32, fed one data bit at a time, lsb first
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	// act on a finished message; returns 1 when it produces a response
	function automatic bit close_message(output resp_t r);
		logic [31:0] mtype;
		logic [31:0] mlen;
		bit hit;
		mtype = hdr[63:32];
		mlen = hdr[31:0];
		hit = 1'b0;
		r = '0;
		if (mtype == MSG_CAPS) begin
			r.kind = KIND_CAPS;
			hit = 1'b1;
		end else if (mtype == MSG_START) begin
			if (mlen >= SMALL_MIN && mlen <= SMALL_MAX) begin
				r.requested_size = lead_word;
				if (lead_word > {8'd0, limit_cfg}) begin
					r.kind = KIND_SIZE_ERR;
				end else begin
					running = 1'b1;
					rx_bytes = '0;
					rx_blocks = '0;
					rx_crc_errs = '0;
					r.kind = KIND_START_ACK;
				end
				hit = 1'b1;
			end
		end else if (mtype == MSG_CSUM) begin
			if (mlen >= SMALL_MIN && mlen <= SMALL_MAX)
				crc_expect = lead_word;
		end else if (mtype == MSG_DATA) begin
			if (mlen != 0 && mlen <= {8'd0, limit_cfg}) begin
				rx_bytes = rx_bytes + mlen;
				rx_blocks = rx_blocks + 1;
				r.computed_crc = ~crc_run;
				if (r.computed_crc != crc_expect) begin
					rx_crc_errs = rx_crc_errs + 1;
					r.kind = KIND_CRC_BAD;
				end else begin
					r.kind = KIND_BLOCK_OK;
				end
				hit = 1'b1;
			end
		end else if (mtype == MSG_STOP) begin
			running = 1'b0;
		end
		r.size_limit = limit_cfg;
		r.bytes_received = rx_bytes;
		r.blocks_received = rx_blocks;
		r.crc_errors = rx_crc_errs;
		r.test_running = running;
		return hit;
	endfunction

	// one stream byte through the shadow receiver
	function automatic bit absorb_byte(input logic [7:0] b, output resp_t r);
		bit hit;
		hit = 1'b0;
		r = '0;
		if (hdr_cnt < HDR_BYTES) begin
			hdr = {hdr[55:0], b};
			hdr_cnt = hdr_cnt + 4'd1;
			if (hdr_cnt == HDR_BYTES) begin
				pay_cnt = '0;
				lead_word = '0;
				crc_run = CRC_INIT;
				// zero length: the message ends with its header
				if (hdr[31:0] == 0) begin
					hit = close_message(r);
					hdr_cnt = '0;
					hdr = '0;
				end
			end
		end else begin
			// only the first four payload bytes form the lead word
			if (pay_cnt < FIRST_BYTES)
				lead_word = {lead_word[23:0], b};
			crc_run = crc_step(crc_run, b);
			pay_cnt = pay_cnt + 1;
			if (pay_cnt == hdr[31:0]) begin
				hit = close_message(r);
				hdr_cnt = '0;
				hdr = '0;
				pay_cnt = '0;
			end
		end
		return hit;
	endfunction

	// idle lengths: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// input driver: one byte per transaction, valid held until accepted
	// ------------------------------------------------------------------
	always @(posedge clk) begin : driver
		resp_t r;
		bit hit;
		bit go;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			go = in_valid;
			if (in_valid && in_ready) begin
				// byte taken: run it through the shadow and queue any response
				hit = absorb_byte(data_byte, r);
				if (hit)
					resp_expect.push_back(r);
				accepted_cnt++;
				send_gap = pick_gap();
				go = 1'b0;
			end
			if (!go) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (tx_bytes.size() != 0) begin
					data_byte <= tx_bytes.pop_front();
					go = 1'b1;
				end
			end
			// single assignment per edge keeps back-to-back transactions clean
			in_valid <= go;
		end
	end

	// ------------------------------------------------------------------
	// response monitor and receiver-side stalls
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : monitor
		resp_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (resp_expect.size() == 0) begin
					$error("response with nothing expected, response_kind %0d", response_kind);
					fails++;
				end else begin
					want = resp_expect.pop_front();
					check_field("response_kind", want.kind, response_kind);
					check_field("requested_size", want.requested_size, requested_size);
					check_field("size_limit", want.size_limit, size_limit);
					check_field("computed_crc", want.computed_crc, computed_crc);
					check_field("bytes_received", want.bytes_received, bytes_received);
					check_field("blocks_received", want.blocks_received, blocks_received);
					check_field("crc_errors", want.crc_errors, crc_errors);
					check_field("test_running", want.test_running, test_running);
					results_seen++;
				end
				recv_wait = pick_gap();
			end else if (!out_valid && recv_wait == 0 && $urandom_range(0, 9) == 0) begin
				// stalls also start while nothing is offered
				recv_wait = pick_gap();
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long hold-off on the response side while bytes keep coming, to back
	// the block up until it stalls its input
	initial begin : backpressure
		while (accepted_cnt < HOLD_AFTER)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_cnt, resp_expect.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// message building
	// ------------------------------------------------------------------
	task automatic push_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			tx_bytes.push_back(w[8*i +: 8]);
	endtask

	// header plus current payload buffer; length is the buffer size
	task automatic emit_msg(input logic [31:0] mtype);
		push_word(mtype);
		push_word(body.size());
		foreach (body[i])
			tx_bytes.push_back(body[i]);
		queued_cnt += 8 + body.size();
	endtask

	// payload of n bytes, lead word in the first four, random after that
	task automatic message(input logic [31:0] mtype, input int n, input logic [31:0] lead);
		body.delete();
		for (int i = 0; i < n; i++)
			body.push_back((i < 4) ? lead[31-8*i -: 8] : 8'($urandom));
		emit_msg(mtype);
	endtask

	// checksum load followed by a data block; pad lengthens the checksum payload
	task automatic data_block(input int n, input bit good, input bit pad);
		logic [7:0] blk[$];
		logic [31:0] sum;
		sum = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			blk.push_back(8'($urandom));
			sum = crc_step(sum, blk[i]);
		end
		sum = ~sum;
		if (!good)
			sum ^= 32'h1 << $urandom_range(0, 31);
		message(MSG_CSUM, pad ? $urandom_range(5, 12) : 4, sum);
		body = blk;
		emit_msg(MSG_DATA);
	endtask

	// config write, only issued with the block idle
	task automatic write_limit(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_cfg = v;
	endtask

	// wait for every byte to be taken and every response to come back
	task automatic drain();
		while (accepted_cnt != queued_cnt || resp_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int block_len();
		if ($urandom_range(0, 24) == 0)
			return $urandom_range(25, 300);
		return $urandom_range(1, 24);
	endfunction

	function automatic int small_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return 4;
		if (r < 19)
			return $urandom_range(5, 12);
		return 256;
	endfunction

	function automatic int bad_small_len();
		if ($urandom_range(0, 1) != 0)
			return $urandom_range(0, 3);
		return $urandom_range(257, 260);
	endfunction

	// requested sizes cluster on the configured limit
	function automatic logic [31:0] pick_req();
		case ($urandom_range(0, 4))
			0: return {8'd0, limit_cfg};
			1: return {8'd0, limit_cfg} + 32'd1;
			2: return $urandom;
			3: return $urandom_range(0, limit_cfg);
			default: return 32'd0;
		endcase
	endfunction

	// mostly well-formed traffic, some wrong lengths and unknown types
	task automatic random_message();
		int pick;
		logic [31:0] t;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			data_block(block_len(), $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
		end else if (pick < 38) begin
			message(MSG_DATA, block_len(), $urandom);
		end else if (pick < 53) begin
			message(MSG_START, small_len(), pick_req());
		end else if (pick < 63) begin
			message(MSG_CAPS, $urandom_range(0, 6), $urandom);
		end else if (pick < 70) begin
			message(MSG_STOP, $urandom_range(0, 3), $urandom);
		end else if (pick < 78) begin
			message(MSG_CSUM, small_len(), $urandom);
		end else if (pick < 90) begin
			case ($urandom_range(0, 3))
				0: message(MSG_START, bad_small_len(), $urandom);
				1: message(MSG_CSUM, bad_small_len(), $urandom);
				2: message(MSG_DATA, 0, 32'd0);
				default: begin
					if (limit_cfg < 300)
						message(MSG_DATA, limit_cfg + 1, $urandom);
					else
						message(MSG_DATA, 0, 32'd0);
				end
			endcase
		end else begin
			t = $urandom;
			if (t == MSG_CAPS || t == MSG_START || t == MSG_CSUM || t == MSG_DATA ||
					t == MSG_STOP)
				t ^= 32'h100;
			message(t, $urandom_range(0, 8), $urandom);
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int mark;
		logic [CFG_W-1:0] lim;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset limit of 32768
		message(MSG_CAPS, 0, 32'd0);                 // ends at the header
		message(MSG_CAPS, 3, 32'hA5A5A5A5);
		message(MSG_START, 4, 32'd1024);
		message(MSG_START, 4, 32'd32769);            // one over the limit
		message(MSG_START, 4, 32'd32768);            // exactly the limit
		message(MSG_START, 3, 32'd16);               // too short, ignored
		message(MSG_START, 257, 32'd16);             // too long, ignored
		message(MSG_START, 256, 32'd0);              // trailing bytes ignored
		data_block(16, 1'b1, 1'b0);
		message(MSG_DATA, 16, 32'h12345678);         // stale checksum
		message(MSG_CSUM, 3, 32'hFFFFFFFF);          // too short, ignored
		data_block(1, 1'b1, 1'b1);
		message(MSG_DATA, 0, 32'd0);                 // empty block, ignored
		message(MSG_STOP, 0, 32'd0);
		message(MSG_STOP, 2, 32'd0);
		message(32'hFFFFFFFF, 5, 32'hFFFFFFFF);      // unknown types
		message(32'h00000000, 0, 32'd0);
		message(MSG_DATA | 32'h80000000, 2, 32'd0);
		message(MSG_DATA | 32'h00000100, 1, 32'd0);
		drain();

		// small limit: block length on both sides of it
		write_limit(24'd300);
		message(MSG_START, 4, 32'd300);
		message(MSG_START, 4, 32'd301);
		data_block(300, 1'b1, 1'b0);
		message(MSG_DATA, 301, 32'd0);
		drain();

		// zero limit: only a zero-size start passes, no block is accepted
		write_limit(24'd0);
		message(MSG_START, 4, 32'd0);
		message(MSG_START, 4, 32'd1);
		message(MSG_DATA, 1, 32'd0);
		message(MSG_CAPS, 0, 32'd0);
		drain();

		// full-scale limit
		write_limit(24'hFFFFFF);
		message(MSG_START, 4, 32'h00FFFFFF);
		message(MSG_START, 4, 32'h01000000);
		data_block(5, 1'b1, 1'b0);
		drain();

		// random phases, each under its own limit; one phase runs without idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 24'hFFFFFF;
				1: lim = 24'd20;
				2: lim = 24'd1;
				3: lim = 24'($urandom_range(2, 24'hFFFFFE));
				4: lim = MAX_BLOCK_RST;
				default: lim = 24'd0;
			endcase
			drain();
			write_limit(lim);
			steady = (ph == 2);
			mark = queued_cnt;
			while (queued_cnt - mark < PHASE_BYTES)
				random_message();
		end
		drain();
		steady = 1'b0;

		$display("sent %0d stream bytes, checked %0d responses, %0d mismatches",
			accepted_cnt, results_seen, fails);
		$display("limits 0, 1, 20, 300, 32768, random and 16777215 were exercised");
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
src/tlvrx_pkg.sv
src/tlvrx_engine.sv
src/tlv_message_receiver_crc32_core.sv
sim/tb_tlv_message_receiver_crc32_core.sv
